>>> rtl/core/bba_pkg.sv
// bba_pkg: shared types and codes for the buddy block allocator
// used by bba_ctrl, bba_datapath and buddy_block_allocator_top; no dependencies
package bba_pkg;

    localparam int WordBits = 32;
    localparam int WordLog  = 5;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OOM = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       load;       // latch request fields
        logic       start;      // set order and block index for the request
        logic       clr;        // clearing pass write
        logic       rd;         // read the word holding the current or buddy bit
        logic       buddy;      // address the buddy block instead of the current one
        logic       scan_next;  // step to the next word of the order
        logic       take;       // claim lowest free bit of the read word
        logic       split;      // go one order down, block index doubled
        logic       wr_set;     // mark current or buddy free
        logic       wr_clr;     // mark buddy taken and go one order up
        logic [1:0] res;        // result status code
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic accept;
        logic is_free;
        logic bad;
        logic found;
        logic ord_eq_need;
        logic ord_top;
        logic word_nz;
        logic bit_hit;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/buddy_block_allocator_top.sv
// buddy_block_allocator_top: binary buddy allocator with valid/ready channels
// depends on bba_pkg, bba_ctrl, bba_datapath
//
// binary buddy allocator over 2^POOL_ORDER minimum blocks. one transaction in
// gives one transaction out. allocate (func 0) rounds request_size up to a
// power-of-two order, picks the smallest order with a free block and within it
// the lowest address, then splits down; free (func 1) returns a block and
// merges it with free buddies on either side. free bits live in a memory of
// 32-bit words, one word read or written per cycle, with a free counter per
// order so the starting order is found in one step. allocate scans the words
// of the chosen order and then splits down level by level; free walks up
// the merge levels and then sets the bit of the merged block; bad requests
// and out-of-memory go straight to the result. a result waits until the
// output register can take it. after reset the block runs a clearing pass
// with s_ready low. a finished result sits in the output register while the
// next transaction is accepted.
module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int POOL_ORDER = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [10:0] s_request_size,
    input  logic [9:0]  s_block_addr,
    input  logic [3:0]  s_block_order,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_granted_addr,
    output logic [3:0]  m_granted_order
);

    cmd_t       cmd;
    sts_t       sts, sts_dp;
    logic       idle, done;
    logic [1:0] res_status;
    logic [9:0] res_addr;
    logic [3:0] res_order;

    logic       m_valid_reg;
    logic [1:0] status_reg;
    logic [9:0] addr_reg;
    logic [3:0] order_reg;

    // input accepted only while the sequencer waits for work
    assign s_ready = idle;

    always_comb begin
        sts          = sts_dp;
        sts.accept   = s_valid && s_ready;
        sts.out_free = !m_valid_reg || m_ready;
    end

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd),
        .idle    (idle),
        .done    (done)
    );

    bba_datapath #(.POOL_ORDER(POOL_ORDER)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_request_size (s_request_size),
        .s_block_addr   (s_block_addr),
        .s_block_order  (s_block_order),
        .sts_dp         (sts_dp),
        .res_status     (res_status),
        .res_addr       (res_addr),
        .res_order      (res_order)
    );

    // output register, loaded only when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            status_reg <= res_status;
            addr_reg   <= res_addr;
            order_reg  <= res_order;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_granted_addr  = addr_reg;
    assign m_granted_order = order_reg;

endmodule

>>> rtl/core/bba_datapath.sv
// bba_datapath: free-bit memory, per-order free counters and request registers
// depends on bba_pkg
module bba_datapath import bba_pkg::*; #(
    parameter int POOL_ORDER = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic        s_func,
    input  logic [10:0] s_request_size,
    input  logic [9:0]  s_block_addr,
    input  logic [3:0]  s_block_order,
    output sts_t        sts_dp,
    output logic [1:0]  res_status,
    output logic [9:0]  res_addr,
    output logic [3:0]  res_order
);

    localparam int OW        = $clog2(POOL_ORDER + 1);
    localparam int SmallBase = (POOL_ORDER >= WordLog) ? ((1 << (POOL_ORDER - 4)) - 1) : 0;
    localparam int Depth     = SmallBase + WordLog;
    localparam int AW        = $clog2(Depth);

    function automatic logic [AW-1:0] widx(input logic [OW-1:0] o,
                                           input logic [POOL_ORDER-1:0] b);
        int nb;
        int r;
        nb = POOL_ORDER - int'(o);
        if (nb >= WordLog) r = ((1 << (nb - WordLog)) - 1) + (int'(b) >> WordLog);
        else r = SmallBase + nb;
        return AW'(r);
    endfunction

    logic                  func_reg;
    logic [10:0]           size_reg;
    logic [9:0]            addr_reg;
    logic [3:0]            bord_reg;
    logic [OW-1:0]         ord_reg, ord_next;
    logic [OW-1:0]         need_reg;
    logic [POOL_ORDER-1:0] blk_reg, blk_next;
    logic [WordBits-1:0]   rdata_reg;
    logic [AW-1:0]         clr_reg;
    logic [POOL_ORDER:0]   cnt_reg [POOL_ORDER+1];
    logic [WordBits-1:0]   mem [Depth];

    logic [3:0]            need4;
    logic [10:0]           sm1;
    logic                  found;
    logic [OW-1:0]         ford;
    logic [4:0]            lb;
    logic                  bad;
    logic [POOL_ORDER-1:0] tgt;
    logic [4:0]            tpos;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WordBits-1:0]   wdata;
    logic                  inc, dec;

    // rounded order of the request size
    always_comb begin
        sm1   = size_reg - 11'd1;
        need4 = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (sm1[i]) need4 = 4'(i + 1);
        end
        if (size_reg == 11'd0) need4 = 4'd0;
    end

    // smallest order at or above need with a free block
    always_comb begin
        found = 1'b0;
        ford  = '0;
        for (int o = 0; o <= POOL_ORDER; o++) begin
            if (!found && o >= int'(need4) && cnt_reg[o] != '0) begin
                found = 1'b1;
                ford  = OW'(o);
            end
        end
    end

    // lowest set bit of the read word
    always_comb begin
        lb = 5'd0;
        for (int i = WordBits - 1; i >= 0; i--) begin
            if (rdata_reg[i]) lb = 5'(i);
        end
    end

    always_comb begin
        if (func_reg == FUNC_ALLOC) begin
            bad = (size_reg == 11'd0) || (int'(need4) > POOL_ORDER);
        end else begin
            bad = (int'(bord_reg) > POOL_ORDER) ||
                  ((int'(addr_reg) & ((1 << int'(bord_reg)) - 1)) != 0) ||
                  (int'(addr_reg) >= (1 << POOL_ORDER));
        end
    end

    assign tgt  = cmd.buddy ? (blk_reg ^ POOL_ORDER'(1)) : blk_reg;
    assign tpos = 5'(tgt);

    always_comb begin
        we    = 1'b0;
        waddr = widx(ord_reg, tgt);
        wdata = rdata_reg;
        inc   = 1'b0;
        dec   = 1'b0;
        if (cmd.clr) begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = (int'(clr_reg) == SmallBase) ? WordBits'(1) : '0;
        end else if (cmd.take) begin
            we    = 1'b1;
            wdata = rdata_reg & ~(WordBits'(1) << lb);
            dec   = 1'b1;
        end else if (cmd.wr_set) begin
            we    = 1'b1;
            wdata = rdata_reg | (WordBits'(1) << tpos);
            // a bit that is already free is not counted twice
            inc   = !rdata_reg[tpos];
        end else if (cmd.wr_clr) begin
            we    = 1'b1;
            wdata = rdata_reg & ~(WordBits'(1) << tpos);
            dec   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd) rdata_reg <= mem[widx(ord_reg, tgt)];
    end

    always_comb begin
        ord_next = ord_reg;
        blk_next = blk_reg;
        if (cmd.start) begin
            if (func_reg == FUNC_ALLOC) begin
                ord_next = ford;
                blk_next = '0;
            end else begin
                ord_next = OW'(bord_reg);
                blk_next = POOL_ORDER'(int'(addr_reg) >> int'(bord_reg));
            end
        end else if (cmd.scan_next) begin
            blk_next = POOL_ORDER'(int'(blk_reg) + WordBits);
        end else if (cmd.take) begin
            blk_next = (blk_reg & ~POOL_ORDER'(WordBits - 1)) | POOL_ORDER'(lb);
        end else if (cmd.split) begin
            ord_next = ord_reg - OW'(1);
            blk_next = blk_reg << 1;
        end else if (cmd.wr_clr) begin
            ord_next = ord_reg + OW'(1);
            blk_next = blk_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            size_reg <= s_request_size;
            addr_reg <= s_block_addr;
            bord_reg <= s_block_order;
        end
        if (cmd.start) need_reg <= OW'(need4);
        ord_reg <= ord_next;
        blk_reg <= blk_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            for (int o = 0; o <= POOL_ORDER; o++) begin
                cnt_reg[o] <= (o == POOL_ORDER) ? (POOL_ORDER + 1)'(1) : '0;
            end
        end else begin
            if (cmd.clr) clr_reg <= clr_reg + AW'(1);
            if (inc) cnt_reg[ord_reg] <= cnt_reg[ord_reg] + (POOL_ORDER + 1)'(1);
            if (dec) cnt_reg[ord_reg] <= cnt_reg[ord_reg] - (POOL_ORDER + 1)'(1);
        end
    end

    always_comb begin
        sts_dp             = '0;
        sts_dp.is_free     = (func_reg == FUNC_FREE);
        sts_dp.bad         = bad;
        sts_dp.found       = found;
        sts_dp.ord_eq_need = (ord_reg == need_reg);
        sts_dp.ord_top     = (int'(ord_reg) == POOL_ORDER);
        sts_dp.word_nz     = (rdata_reg != '0);
        sts_dp.bit_hit     = rdata_reg[tpos];
        sts_dp.clr_last    = (int'(clr_reg) == Depth - 1);
    end

    always_comb begin
        res_status = cmd.res;
        res_addr   = '0;
        res_order  = '0;
        if (cmd.res == STATUS_OK) begin
            res_order = 4'(ord_reg);
            if (func_reg == FUNC_ALLOC) res_addr = 10'(int'(blk_reg) << int'(need_reg));
        end
    end

    a_take_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> rdata_reg != '0) else $error("take on an empty word");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        dec |-> cnt_reg[ord_reg] != '0) else $error("free counter underflow");
    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> int'(ord_reg) <= POOL_ORDER) else $error("order out of range");

endmodule

>>> rtl/core/bba_ctrl.sv
// bba_ctrl: request sequencer for the buddy block allocator
// depends on bba_pkg
module bba_ctrl import bba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  sts_t sts,
    output cmd_t cmd,
    output logic idle,
    output logic done
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CHK, S_SPLIT, S_SPLIT_RD,
        S_SPLIT_WR, S_MRG, S_MRG_CHK, S_SET_RD, S_SET_WR, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (sts.accept) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_next = STATUS_OK;
                if (sts.bad) begin
                    res_next   = STATUS_BAD;
                    state_next = S_DONE;
                end else if (!sts.is_free && !sts.found) begin
                    res_next   = STATUS_OOM;
                    state_next = S_DONE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = sts.is_free ? S_MRG : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (sts.word_nz) begin
                    cmd.take   = 1'b1;
                    state_next = sts.ord_eq_need ? S_DONE : S_SPLIT;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_SPLIT_RD;
            end
            S_SPLIT_RD: begin
                cmd.rd     = 1'b1;
                cmd.buddy  = 1'b1;
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                cmd.wr_set = 1'b1;
                cmd.buddy  = 1'b1;
                state_next = sts.ord_eq_need ? S_DONE : S_SPLIT;
            end
            S_MRG: begin
                if (sts.ord_top) begin
                    state_next = S_SET_RD;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.buddy  = 1'b1;
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK: begin
                cmd.buddy = 1'b1;
                if (sts.bit_hit) begin
                    cmd.wr_clr = 1'b1;
                    state_next = S_MRG;
                end else begin
                    state_next = S_SET_RD;
                end
            end
            S_SET_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SET_WR;
            end
            S_SET_WR: begin
                cmd.wr_set = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            res_reg   <= STATUS_OK;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule
